@@ design/grid_block_average_downsampler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid block average downsampler
// Clocked on clk_i, disabled while rst_ni is low unless noted.
// ----------------------------------------------------------------------------
`ifndef GRID_BLOCK_AVERAGE_DOWNSAMPLER_ASSERT_SVH
`define GRID_BLOCK_AVERAGE_DOWNSAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define GBAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GBAD_ASSERT(lbl, prop, msg)
`define GBAD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/gbad_pkg.sv @@
// ----------------------------------------------------------------------------
// gbad_pkg
// Shared widths, register codes, state encoding and flag types.
// ----------------------------------------------------------------------------
package gbad_pkg;

  localparam int DATA_W       = 32;
  localparam int SIZE_W       = 9;
  localparam int STEP_W       = 4;
  localparam int COORD_W      = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int DEF_MAX_DIM  = 256;
  localparam int DEF_MAX_STEP = 8;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_STEP   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACC,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic first;
    logic last;
    logic done;
  } blk_flags_t;

endpackage

@@ design/gbad_front.sv @@
// ----------------------------------------------------------------------------
// gbad_front
// Configuration registers, grid position tracking and sample classification.
// ----------------------------------------------------------------------------
module gbad_front #(
  parameter int MAX_DIM  = gbad_pkg::DEF_MAX_DIM,
  parameter int MAX_STEP = gbad_pkg::DEF_MAX_STEP,
  localparam int POS_W   = $clog2(MAX_DIM),
  localparam int AW      = 2 * POS_W,
  localparam int OFS_W   = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1,
  localparam int EXT_W   = $clog2(MAX_STEP + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbad_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gbad_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                q_full_i,
  output logic                                push_o,
  output logic [AW-1:0]                       idx_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_x_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_y_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_z_o,
  output logic [2*EXT_W-1:0]                  ext_xy_o,
  output logic [EXT_W-1:0]                    ext_z_o,
  output gbad_pkg::blk_flags_t                flags_o
);
  import gbad_pkg::*;

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [STEP_W-1:0] step_q;
  logic [POS_W-1:0]  x_q, y_q, z_q, x_d, y_d, z_d;
  logic [POS_W-1:0]  bx_q, by_q, bz_q, bx_d, by_d, bz_d;
  logic [OFS_W-1:0]  ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic [AW-1:0]     idx_q, idx_d, row_q, row_d;
  logic [POS_W-1:0]  nx_m1, ny_m1, nz_m1;
  logic [OFS_W-1:0]  s_m1;
  logic              cfg_we;
  logic              x_end, y_end, z_end;
  logic [EXT_W-1:0]  ext_x, ext_y;

  function automatic logic [POS_W-1:0] eff_m1(input logic [SIZE_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_DIM) begin
      r = POS_W'(MAX_DIM - 1);
    end else begin
      r = POS_W'(v - SIZE_W'(1));
    end
    return r;
  endfunction

  assign nx_m1 = eff_m1(size_x_q);
  assign ny_m1 = eff_m1(size_y_q);
  assign nz_m1 = eff_m1(size_z_q);

  always_comb begin
    if (step_q == '0) begin
      s_m1 = '0;
    end else if (32'(step_q) > MAX_STEP) begin
      s_m1 = OFS_W'(MAX_STEP - 1);
    end else begin
      s_m1 = OFS_W'(step_q - STEP_W'(1));
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;

  assign x_end = (x_q == nx_m1);
  assign y_end = (y_q == ny_m1);
  assign z_end = (z_q == nz_m1);

  assign flags_o.first = (ox_q == '0) && (oy_q == '0) && (oz_q == '0);
  assign flags_o.last  = ((ox_q == s_m1) || x_end) && ((oy_q == s_m1) || y_end) &&
                         ((oz_q == s_m1) || z_end);
  assign flags_o.done  = x_end && y_end && z_end;

  assign ext_x    = EXT_W'(ox_q) + EXT_W'(1);
  assign ext_y    = EXT_W'(oy_q) + EXT_W'(1);
  assign ext_z_o  = EXT_W'(oz_q) + EXT_W'(1);
  assign ext_xy_o = (2*EXT_W)'(ext_x) * (2*EXT_W)'(ext_y);

  assign idx_o      = idx_q;
  assign coarse_x_o = COORD_W'(bx_q);
  assign coarse_y_o = COORD_W'(by_q);
  assign coarse_z_o = COORD_W'(bz_q);

  always_comb begin
    x_d = x_q;  y_d = y_q;  z_d = z_q;
    bx_d = bx_q; by_d = by_q; bz_d = bz_q;
    ox_d = ox_q; oy_d = oy_q; oz_d = oz_q;
    idx_d = idx_q; row_d = row_q;
    if (cfg_we) begin
      x_d = '0;  y_d = '0;  z_d = '0;
      bx_d = '0; by_d = '0; bz_d = '0;
      ox_d = '0; oy_d = '0; oz_d = '0;
      idx_d = '0; row_d = '0;
    end else if (push_o) begin
      if (!z_end) begin
        z_d = z_q + POS_W'(1);
        if (oz_q == s_m1) begin
          oz_d  = '0;
          bz_d  = bz_q + POS_W'(1);
          idx_d = idx_q + AW'(1);
        end else begin
          oz_d = oz_q + OFS_W'(1);
        end
      end else begin
        z_d = '0; oz_d = '0; bz_d = '0;
        if (!y_end) begin
          y_d = y_q + POS_W'(1);
          if (oy_q == s_m1) begin
            oy_d  = '0;
            by_d  = by_q + POS_W'(1);
            idx_d = idx_q + AW'(1);
            row_d = idx_q + AW'(1);
          end else begin
            oy_d  = oy_q + OFS_W'(1);
            idx_d = row_q;
          end
        end else begin
          y_d = '0; oy_d = '0; by_d = '0;
          idx_d = '0; row_d = '0;
          if (!x_end) begin
            x_d = x_q + POS_W'(1);
            if (ox_q == s_m1) begin
              ox_d = '0;
              bx_d = bx_q + POS_W'(1);
            end else begin
              ox_d = ox_q + OFS_W'(1);
            end
          end else begin
            x_d = '0; ox_d = '0; bx_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_W'(1);
      size_y_q <= SIZE_W'(1);
      size_z_q <= SIZE_W'(1);
      step_q   <= STEP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SIZE_X: size_x_q <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y: size_y_q <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z: size_z_q <= cfg_data_i[SIZE_W-1:0];
        REG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;  y_q <= '0;  z_q <= '0;
      bx_q <= '0; by_q <= '0; bz_q <= '0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0;
      idx_q <= '0; row_q <= '0;
    end else begin
      x_q <= x_d;  y_q <= y_d;  z_q <= z_d;
      bx_q <= bx_d; by_q <= by_d; bz_q <= bz_d;
      ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d;
      idx_q <= idx_d; row_q <= row_d;
    end
  end

endmodule

@@ design/gbad_fifo.sv @@
// ----------------------------------------------------------------------------
// gbad_fifo
// Short queue decoupling sample classification from accumulation.
// ----------------------------------------------------------------------------
`include "grid_block_average_downsampler_assert.svh"

module gbad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gbad_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `GBAD_ASSERT(a_fifo_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")
  `GBAD_ASSERT(a_fifo_fill, (push_i && !pop_i) |=> !empty_o, "queue lost a transaction")
  `GBAD_ASSERT(a_fifo_no_under, pop_i |-> !empty_o, "pop from an empty queue")

endmodule

@@ design/gbad_back.sv @@
// ----------------------------------------------------------------------------
// gbad_back
// Accumulator plane read-modify-write, serial divide and result register.
// ----------------------------------------------------------------------------
`include "grid_block_average_downsampler_assert.svh"

module gbad_back #(
  parameter int MAX_DIM  = gbad_pkg::DEF_MAX_DIM,
  parameter int MAX_STEP = gbad_pkg::DEF_MAX_STEP,
  localparam int POS_W   = $clog2(MAX_DIM),
  localparam int AW      = 2 * POS_W,
  localparam int EXT_W   = $clog2(MAX_STEP + 1),
  localparam int SUM_W   = gbad_pkg::DATA_W + $clog2(MAX_STEP ** 3) + 1,
  localparam int CNT_W   = $clog2(MAX_STEP ** 3 + 1),
  localparam int DC_W    = $clog2(SUM_W),
  localparam int MEM_D   = MAX_DIM * MAX_DIM
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  output logic                                q_pop_o,
  input  logic signed [gbad_pkg::DATA_W-1:0]  q_sample_i,
  input  logic [AW-1:0]                       q_idx_i,
  input  logic [gbad_pkg::COORD_W-1:0]        q_cx_i,
  input  logic [gbad_pkg::COORD_W-1:0]        q_cy_i,
  input  logic [gbad_pkg::COORD_W-1:0]        q_cz_i,
  input  logic [2*EXT_W-1:0]                  q_ext_xy_i,
  input  logic [EXT_W-1:0]                    q_ext_z_i,
  input  gbad_pkg::blk_flags_t                q_flags_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gbad_pkg::DATA_W-1:0]  average_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_x_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_y_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_z_o,
  output logic                                grid_done_o
);
  import gbad_pkg::*;

  logic [SUM_W-1:0]   mem [MEM_D];
  back_state_e        state_q, state_d;
  logic [DATA_W-1:0]  cur_sample_q;
  logic [AW-1:0]      cur_idx_q;
  logic [COORD_W-1:0] cur_cx_q, cur_cy_q, cur_cz_q;
  logic [2*EXT_W-1:0] cur_ext_xy_q;
  logic [EXT_W-1:0]   cur_ext_z_q;
  blk_flags_t         cur_flags_q;
  logic [SUM_W-1:0]   rd_data_q;
  logic [SUM_W-1:0]   sample_ext, sum, mag;
  logic [3*EXT_W-1:0] cnt_full;
  logic               neg_q;
  logic [SUM_W-1:0]   quo_q, quo_n, res;
  logic [CNT_W-1:0]   rem_q, divisor_q;
  logic [CNT_W:0]     rem_sh, rem_sub;
  logic               ge;
  logic [DC_W-1:0]    dcnt_q;
  logic               mem_we, load_out, div_last;
  logic               out_valid_q;
  logic [DATA_W-1:0]  average_q;
  logic [COORD_W-1:0] out_cx_q, out_cy_q, out_cz_q;
  logic               out_done_q;

  assign sample_ext = {{(SUM_W-DATA_W){cur_sample_q[DATA_W-1]}}, cur_sample_q};
  assign sum        = cur_flags_q.first ? sample_ext : rd_data_q + sample_ext;
  assign mag        = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign cnt_full   = (3*EXT_W)'(cur_ext_xy_q) * (3*EXT_W)'(cur_ext_z_q);

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor_q});
  assign rem_sub = ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
  assign quo_n   = {quo_q[SUM_W-2:0], ge};
  assign res     = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign div_last = (dcnt_q == DC_W'(SUM_W - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!q_empty_i) state_d = BK_ACC;
      BK_ACC:  state_d = cur_flags_q.last ? BK_DIV : BK_IDLE;
      BK_DIV:  if (div_last) state_d = BK_EMIT;
      BK_EMIT: if (!out_valid_q || !out_stall_i) state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: q_pop_o  = !q_empty_i;
      BK_ACC:  mem_we   = 1'b1;
      BK_DIV:  ;
      BK_EMIT: load_out = !out_valid_q || !out_stall_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cur_idx_q] <= sum;
    end
    if (q_pop_o) begin
      rd_data_q <= mem[q_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_DIV) begin
        dcnt_q <= div_last ? '0 : dcnt_q + DC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_sample_q <= q_sample_i;
      cur_idx_q    <= q_idx_i;
      cur_cx_q     <= q_cx_i;
      cur_cy_q     <= q_cy_i;
      cur_cz_q     <= q_cz_i;
      cur_ext_xy_q <= q_ext_xy_i;
      cur_ext_z_q  <= q_ext_z_i;
      cur_flags_q  <= q_flags_i;
    end
    if (state_q == BK_ACC) begin
      neg_q     <= sum[SUM_W-1];
      quo_q     <= mag;
      rem_q     <= '0;
      divisor_q <= CNT_W'(cnt_full);
    end else if (state_q == BK_DIV) begin
      quo_q <= quo_n;
      rem_q <= rem_sub[CNT_W-1:0];
    end
    if (load_out) begin
      average_q  <= res[DATA_W-1:0];
      out_cx_q   <= cur_cx_q;
      out_cy_q   <= cur_cy_q;
      out_cz_q   <= cur_cz_q;
      out_done_q <= cur_flags_q.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign coarse_x_o  = out_cx_q;
  assign coarse_y_o  = out_cy_q;
  assign coarse_z_o  = out_cz_q;
  assign grid_done_o = out_done_q;

  `GBAD_ASSERT(a_acc_after_pop, (state_q == BK_ACC) |-> $past(q_pop_o), "accumulate without read")
  `GBAD_ASSERT(a_div_nonzero, (state_q == BK_DIV) |-> (divisor_q != '0), "zero block count")
  `GBAD_ASSERT(a_load_free, load_out |-> (!out_valid_q || !out_stall_i), "result overwritten")

endmodule

@@ design/grid_block_average_downsampler.sv @@
// ----------------------------------------------------------------------------
// grid_block_average_downsampler
// Averages cubic blocks of a streamed 3D Q16.16 grid into a coarse grid.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | sample_i
//  out     | output    | out_valid_o/out_stall_i | average_o, coarse_x/y/z_o, grid_done_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  The front takes one sample per cycle while the four-entry queue has room.
//  The back reads an accumulator entry when idle and writes it back when
//  accumulating (one memory port, registered read); a block's last sample adds
//  a restoring division over SUM_W quotient bits (42 at default sizes) and a
//  result register load. Reset needs no clearing pass: each accumulator entry
//  is written by its block's first sample. A stalled result holds the result
//  register; the back then waits and the queue and front fill behind it.
// ----------------------------------------------------------------------------
module grid_block_average_downsampler #(
  parameter int MAX_DIM  = gbad_pkg::DEF_MAX_DIM,
  parameter int MAX_STEP = gbad_pkg::DEF_MAX_STEP
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbad_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gbad_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gbad_pkg::DATA_W-1:0]  sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gbad_pkg::DATA_W-1:0]  average_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_x_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_y_o,
  output logic [gbad_pkg::COORD_W-1:0]        coarse_z_o,
  output logic                                grid_done_o
);
  import gbad_pkg::*;

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int AW    = 2 * POS_W;
  localparam int EXT_W = $clog2(MAX_STEP + 1);
  localparam int Q_W   = DATA_W + AW + 3*COORD_W + 3*EXT_W + $bits(blk_flags_t);

  logic               push, pop, q_full, q_empty;
  logic [AW-1:0]      f_idx, q_idx;
  logic [COORD_W-1:0] f_cx, f_cy, f_cz, q_cx, q_cy, q_cz;
  logic [2*EXT_W-1:0] f_ext_xy, q_ext_xy;
  logic [EXT_W-1:0]   f_ext_z, q_ext_z;
  blk_flags_t         f_flags, q_flags;
  logic [DATA_W-1:0]  q_sample;
  logic [Q_W-1:0]     q_wdata, q_rdata;

  gbad_front #(
    .MAX_DIM  (MAX_DIM),
    .MAX_STEP (MAX_STEP)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .idx_o       (f_idx),
    .coarse_x_o  (f_cx),
    .coarse_y_o  (f_cy),
    .coarse_z_o  (f_cz),
    .ext_xy_o    (f_ext_xy),
    .ext_z_o     (f_ext_z),
    .flags_o     (f_flags)
  );

  assign q_wdata = {sample_i, f_idx, f_cx, f_cy, f_cz, f_ext_xy, f_ext_z, f_flags};

  gbad_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {q_sample, q_idx, q_cx, q_cy, q_cz, q_ext_xy, q_ext_z, q_flags} = q_rdata;

  gbad_back #(
    .MAX_DIM  (MAX_DIM),
    .MAX_STEP (MAX_STEP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (pop),
    .q_sample_i  (q_sample),
    .q_idx_i     (q_idx),
    .q_cx_i      (q_cx),
    .q_cy_i      (q_cy),
    .q_cz_i      (q_cz),
    .q_ext_xy_i  (q_ext_xy),
    .q_ext_z_i   (q_ext_z),
    .q_flags_i   (q_flags),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .coarse_x_o  (coarse_x_o),
    .coarse_y_o  (coarse_y_o),
    .coarse_z_o  (coarse_z_o),
    .grid_done_o (grid_done_o)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: grid block average downsampler testbench
// Streams 3D grids of Q16.16 samples under a range of grid and step settings.
// Each accepted sample feeds a behavioural copy of the block, and every result
// is checked field by field against the oldest predicted coarse cell. Random
// gaps on the sample side and random stalls on the result side are applied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gbad_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int ITEMS_TARGET  = 1650;
  localparam int CELLS_WANTED  = 60;

  typedef struct {
    logic signed [DATA_W-1:0] average;
    logic [COORD_W-1:0]       cx;
    logic [COORD_W-1:0]       cy;
    logic [COORD_W-1:0]       cz;
    logic                     done;
  } coarse_cell_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = REG_SIZE_X;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] sample_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] average_o;
  logic [COORD_W-1:0]       coarse_x_o;
  logic [COORD_W-1:0]       coarse_y_o;
  logic [COORD_W-1:0]       coarse_z_o;
  logic                     grid_done_o;

  coarse_cell_t   expected_cells[$];
  coarse_cell_t   want;
  longint         block_sums[int unsigned];
  logic [SIZE_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
  logic [STEP_W-1:0] step_reg;
  int unsigned    at_x, at_y, at_z;
  int             failures = 0;
  int             samples_sent = 0;
  int             cells_due = 0;
  int             gap_pct = 0;
  int             stall_pct = 0;
  int             stall_left = 0;

  grid_block_average_downsampler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .coarse_x_o  (coarse_x_o),
    .coarse_y_o  (coarse_y_o),
    .coarse_z_o  (coarse_z_o),
    .grid_done_o (grid_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned clamp_step(logic [STEP_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_STEP) return DEF_MAX_STEP;
    return v;
  endfunction

  function automatic int unsigned clipped_extent(int unsigned n, int unsigned blk,
                                                 int unsigned s);
    int unsigned rest;
    rest = n - blk * s;
    return (rest < s) ? rest : s;
  endfunction

  function automatic void load_reg(cfg_reg_e id, logic [CFG_DATA_W-1:0] word);
    case (id)
      REG_SIZE_X: grid_x_reg = word;
      REG_SIZE_Y: grid_y_reg = word;
      REG_SIZE_Z: grid_z_reg = word;
      REG_STEP:   step_reg = word[STEP_W-1:0];
      default: ;
    endcase
    at_x = 0;
    at_y = 0;
    at_z = 0;
  endfunction

  function automatic void predict_cell(logic signed [DATA_W-1:0] value);
    int unsigned  nx, ny, nz, s, bx, by, bz, cnz, idx;
    bit           is_first, is_last, is_done;
    longint       cnt, avg;
    coarse_cell_t entry;
    nx = clamp_size(grid_x_reg);
    ny = clamp_size(grid_y_reg);
    nz = clamp_size(grid_z_reg);
    s  = clamp_step(step_reg);
    bx = at_x / s;
    by = at_y / s;
    bz = at_z / s;
    cnz = (nz + s - 1) / s;
    idx = (by * cnz + bz) % (DEF_MAX_DIM * DEF_MAX_DIM);
    is_first = (at_x % s == 0) && (at_y % s == 0) && (at_z % s == 0);
    if (is_first) block_sums[idx] = longint'(value);
    else block_sums[idx] += longint'(value);
    is_last = (at_x % s == s - 1 || at_x == nx - 1) &&
              (at_y % s == s - 1 || at_y == ny - 1) &&
              (at_z % s == s - 1 || at_z == nz - 1);
    is_done = (at_x == nx - 1) && (at_y == ny - 1) && (at_z == nz - 1);
    if (is_last) begin
      cnt = longint'(clipped_extent(nx, bx, s)) * longint'(clipped_extent(ny, by, s)) *
            longint'(clipped_extent(nz, bz, s));
      avg = block_sums[idx] / cnt;
      entry.average = avg[DATA_W-1:0];
      entry.cx = bx[COORD_W-1:0];
      entry.cy = by[COORD_W-1:0];
      entry.cz = bz[COORD_W-1:0];
      entry.done = is_done;
      expected_cells = {expected_cells, entry};
      cells_due++;
    end
    at_z++;
    if (at_z >= nz) begin
      at_z = 0;
      at_y++;
      if (at_y >= ny) begin
        at_y = 0;
        at_x++;
        if (at_x >= nx) at_x = 0;
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = int'($urandom_range(0, 131072)) - 65536;
      3: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: v = int'($urandom_range(0, 200 * 65536)) - 100 * 65536;
    endcase
    return v;
  endfunction

  always @(negedge clk_i) begin
    if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 14);
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_cells.size() == 0) begin
        $display("%0t tb_top: unexpected result, expected none, got average %0d (%0d,%0d,%0d)",
                 $time, average_o, coarse_x_o, coarse_y_o, coarse_z_o);
        failures++;
      end else begin
        want = expected_cells.pop_front();
        if (average_o !== want.average) begin
          $display("%0t tb_top: average mismatch, expected %0d, got %0d",
                   $time, want.average, average_o);
          failures++;
        end
        if (coarse_x_o !== want.cx) begin
          $display("%0t tb_top: coarse_x mismatch, expected %0d, got %0d",
                   $time, want.cx, coarse_x_o);
          failures++;
        end
        if (coarse_y_o !== want.cy) begin
          $display("%0t tb_top: coarse_y mismatch, expected %0d, got %0d",
                   $time, want.cy, coarse_y_o);
          failures++;
        end
        if (coarse_z_o !== want.cz) begin
          $display("%0t tb_top: coarse_z mismatch, expected %0d, got %0d",
                   $time, want.cz, coarse_z_o);
          failures++;
        end
        if (grid_done_o !== want.done) begin
          $display("%0t tb_top: grid_done mismatch, expected %0b, got %0b",
                   $time, want.done, grid_done_o);
          failures++;
        end
      end
    end
  end

  // Hold valid high across back-to-back transactions; drop it only for a gap.
  task automatic send_sample(input logic signed [DATA_W-1:0] value);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cell(value);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic stream_random(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
    in_valid_i <= 1'b0;
  endtask

  task automatic settle_block();
    while (expected_cells.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e id, input logic [CFG_DATA_W-1:0] word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= id;
    cfg_data_i  <= word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    load_reg(id, word);
    @(negedge clk_i);
  endtask

  task automatic program_grid(input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                              input logic [CFG_DATA_W-1:0] sz,
                              input logic [CFG_DATA_W-1:0] step_word);
    logic [CFG_DATA_W-1:0] words[4];
    int                    start;
    cfg_reg_e              id;
    settle_block();
    words[REG_SIZE_X] = sx;
    words[REG_SIZE_Y] = sy;
    words[REG_SIZE_Z] = sz;
    words[REG_STEP]   = step_word;
    start = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      id = cfg_reg_e'((start + k) % 4);
      write_reg(id, words[id]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_single_cell_defaults();
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0000);
    send_sample(-32'sd1);
    send_sample(32'sh0000_0001);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_zero_registers();
    program_grid(9'd0, 9'd0, 9'd0, 9'h1F0);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_clipped_blocks();
    program_grid(9'd2, 9'd1, 9'd3, 9'd2);
    send_sample(-32'sd5);
    send_sample(32'sd3);
    send_sample(-32'sd2);
    send_sample(-32'sd1);
    send_sample(32'sd0);
    send_sample(32'sh8000_0000);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_restart_mid_grid();
    send_sample(32'sh0001_8000);
    send_sample(-32'sh0000_4000);
    in_valid_i <= 1'b0;
    settle_block();
    write_reg(REG_STEP, 9'd2);
    cfg_valid_i <= 1'b0;
    stream_random(6);
  endtask

  task automatic test_largest_axes();
    gap_pct = 10;
    stall_pct = 10;
    program_grid(9'd511, 9'd1, 9'd1, 9'h00F);
    stream_random(256);
    program_grid(9'd1, 9'd300, 9'd1, 9'h1E8);
    stream_random(256);
    program_grid(9'd1, 9'd1, 9'd256, 9'd1);
    stream_random(256);
  endtask

  task automatic test_random_grids();
    logic [CFG_DATA_W-1:0] sx, sy, sz;
    int                    volume, count;
    while (samples_sent < ITEMS_TARGET || cells_due < CELLS_WANTED) begin
      if (samples_sent >= ITEMS_TARGET - 200) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if ($urandom_range(0, 7) == 0) begin
        sx = $urandom_range(0, 2);
        sy = $urandom_range(0, 2);
        sz = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0: sx = $urandom_range(9, 511);
          1: sy = $urandom_range(9, 511);
          default: sz = $urandom_range(9, 511);
        endcase
      end else begin
        sx = $urandom_range(0, 8);
        sy = $urandom_range(0, 8);
        sz = $urandom_range(0, 8);
      end
      program_grid(sx, sy, sz, CFG_DATA_W'($urandom_range(0, 511)));
      volume = clamp_size(sx) * clamp_size(sy) * clamp_size(sz);
      if (volume > 300 || $urandom_range(0, 5) == 0)
        count = $urandom_range(1, (volume > 300) ? 300 : volume);
      else if (volume <= 100)
        count = volume * $urandom_range(1, 2);
      else
        count = volume;
      stream_random(count);
    end
  endtask

  task automatic finish_run();
    settle_block();
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  endtask

  initial begin
    grid_x_reg = 9'd1;
    grid_y_reg = 9'd1;
    grid_z_reg = 9'd1;
    step_reg   = 4'd1;
    at_x = 0;
    at_y = 0;
    at_z = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_single_cell_defaults();
    test_zero_registers();
    test_clipped_blocks();
    test_restart_mid_grid();
    test_largest_axes();
    test_random_grids();
    finish_run();
  end

  initial begin
    #(10_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
